@@ sv/mfek_pkg.sv @@
// Package: types, states and constants of the max-flow engine.
`default_nettype none
package mfek_pkg;
    localparam int CAP_W  = 16;
    localparam int RES_W  = 17;
    localparam int FLOW_W = 22;
    localparam logic [FLOW_W-1:0] FLOW_LIMIT = 22'h3FFFFF;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;
    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE     = 2'd1;
    localparam logic [1:0] REG_SINK       = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_COPY, ST_BFS_INIT, ST_BFS_POP, ST_BFS_SCAN,
        ST_NECK, ST_UPD_FWD, ST_UPD_REV, ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic copy_start;
        logic copy_step;
        logic bfs_init;
        logic bfs_pop;
        logic scan_step;
        logic walk_start;
        logic neck_step;
        logic fwd_step;
        logic rev_step;
        logic add_flow;
        logic zero_flow;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic copy_last;
        logic queue_empty;
        logic scan_last;
        logic scan_pend;
        logic sink_seen;
        logic walk_last;
    } stat_t;
endpackage
`default_nettype wire

@@ sv/max_flow_edmonds_karp_top.sv @@
// Top level of the max-flow engine: handshakes, configuration and result register.
//
// Input channel (s_valid/s_ready) carries one command per transfer. A write
// command (s_command = 0) stores s_capacity at row s_from_node, column
// s_to_node of the capacity matrix; writes stream at one per cycle while
// s_ready is high. A run command (s_command = 1) copies the matrix into the
// residual memory (N*N entries, N = MAX_NODES, rounded up to a power of two),
// then repeats a breadth-first search and a path walk until the sink is
// unreachable. s_ready is low during a run.
// Result channel (m_valid/m_ready) gives one m_total_flow transfer per run.
// The result register holds the value while the receiver stalls; no new
// command is taken until it has gone.
// Reset: synchronous, active low. A clearing pass then zeroes the N*N
// capacity matrix, with s_ready low; configuration writes are taken.
`default_nettype none
module max_flow_edmonds_karp_top #(
    parameter int MAX_NODES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [5:0]  s_from_node,
    input  wire logic [5:0]  s_to_node,
    input  wire logic [15:0] s_capacity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [21:0]      m_total_flow
);
    import mfek_pkg::*;
    localparam int IDX_W = $clog2(MAX_NODES);

    logic [6:0] node_count_reg;
    logic [5:0] source_reg, sink_reg;
    logic       m_valid_reg;
    logic [21:0] m_data_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  idle, done, take, run_take, trivial, wr_en;
    logic [8:0] n_full;
    logic [IDX_W:0] n_use;
    logic [21:0] flow;

    // Configuration: index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 7'd64; source_reg <= '0; sink_reg <= 6'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data;
                REG_SOURCE:     source_reg <= cfg_data[5:0];
                REG_SINK:       sink_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamp node count to the built size.
    assign n_full = (9'(node_count_reg) > 9'(MAX_NODES)) ? 9'(MAX_NODES) : 9'(node_count_reg);
    assign n_use  = (IDX_W+1)'(n_full);
    assign trivial = 9'(source_reg) >= n_full || 9'(sink_reg) >= n_full
                     || source_reg == sink_reg;

    assign s_ready  = idle && !m_valid_reg;
    assign take     = s_valid && s_ready;
    assign run_take = take && s_command == CMD_RUN;
    // Out-of-range coordinates only exist when MAX_NODES is below 64.
    assign wr_en    = take && s_command == CMD_WRITE
                      && 9'(s_from_node) < 9'(MAX_NODES) && 9'(s_to_node) < 9'(MAX_NODES);

    mfek_ctrl u_ctrl (
        .aclk, .aresetn, .run_take, .run_trivial(trivial),
        .out_free(!m_valid_reg), .stat, .cmd, .idle, .done
    );

    mfek_datapath #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .wr_en,
        .wr_row(IDX_W'(s_from_node)), .wr_col(IDX_W'(s_to_node)),
        .wr_data(s_capacity), .n_use,
        .src(IDX_W'(source_reg)), .dst(IDX_W'(sink_reg)), .flow
    );

    // Result register: load on completion, hold while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (done && !m_valid_reg) begin
            m_valid_reg <= 1'b1; m_data_reg <= flow;
        end else if (m_ready) m_valid_reg <= 1'b0;
    end
    assign m_valid = m_valid_reg;
    assign m_total_flow = m_data_reg;
endmodule
`default_nettype wire

@@ sv/mfek_datapath.sv @@
// Datapath: capacity and residual memories, search storage and flow register.
`default_nettype none
module mfek_datapath #(
    parameter int MAX_NODES = 64,
    parameter int IDX_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mfek_pkg::cmd_t    cmd,
    output mfek_pkg::stat_t        stat,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_row,
    input  wire logic [IDX_W-1:0]  wr_col,
    input  wire logic [15:0]       wr_data,
    input  wire logic [IDX_W:0]    n_use,
    input  wire logic [IDX_W-1:0]  src,
    input  wire logic [IDX_W-1:0]  dst,
    output logic [21:0]            flow
);
    import mfek_pkg::*;
    localparam int AW = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;

    logic [CAP_W-1:0] cap_mem [DEPTH];
    logic [RES_W-1:0] res_mem [DEPTH];
    logic             vis_reg [MAX_NODES];
    logic [IDX_W-1:0] par_mem [MAX_NODES];
    logic [IDX_W-1:0] que_mem [MAX_NODES];

    logic [AW:0]      clr_reg;
    logic [AW:0]      cp_reg;
    logic [AW-1:0]    cp_d_reg;
    logic             cp_v_reg;
    logic [IDX_W:0]   head_reg, tail_reg;
    logic [IDX_W-1:0] u_reg, v_reg;
    logic             sv_reg;
    logic [IDX_W-1:0] w_reg, wp_reg, pw_reg;
    logic [IDX_W:0]   steps_reg;
    logic [RES_W-1:0] neck_reg;
    logic             nv_reg;
    logic             rv_reg;
    logic [AW-1:0]    ra_reg;
    logic [FLOW_W-1:0] flow_reg;
    logic [CAP_W-1:0] cap_rd;
    logic [RES_W-1:0] res_rd;

    // Residual read address, chosen by what the controller is doing.
    logic [AW-1:0] rd_addr;
    logic [IDX_W-1:0] v_scan;
    always_comb begin
        v_scan = v_reg;
        rd_addr = {u_reg, v_scan};
        if (cmd.neck_step || cmd.walk_start || cmd.fwd_step) rd_addr = {pw_reg, w_reg};
        if (cmd.rev_step) rd_addr = {w_reg, wp_reg};
    end

    // Forward residual is written back on the reverse step, the reverse one on the step after.
    always_ff @(posedge aclk) begin
        if (wr_en) cap_mem[{wr_row, wr_col}] <= wr_data;
        else if (cmd.clr_step) cap_mem[clr_reg[AW-1:0]] <= '0;
        cap_rd <= cap_mem[cp_reg[AW-1:0]];
        res_rd <= res_mem[rd_addr];
        if (cp_v_reg) res_mem[cp_d_reg] <= {1'b0, cap_rd};
        else if (cmd.rev_step) res_mem[{wp_reg, w_reg}] <= res_rd - neck_reg;
        else if (rv_reg) res_mem[ra_reg] <= res_rd + neck_reg;
    end

    // Scan pipeline: a scan step issues the read of v and registers v as w_reg with sv_reg set, alongside res_rd.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0; cp_reg <= '0; cp_v_reg <= 1'b0;
            head_reg <= '0; tail_reg <= '0; flow_reg <= '0; sv_reg <= 1'b0;
            nv_reg <= 1'b0; rv_reg <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) vis_reg[i] <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            cp_v_reg <= cmd.copy_step;
            cp_d_reg <= cp_reg[AW-1:0];
            if (cmd.copy_start) cp_reg <= '0;
            else if (cmd.copy_step) cp_reg <= cp_reg + 1'b1;
            if (cmd.bfs_init) begin
                for (int i = 0; i < MAX_NODES; i++) vis_reg[i] <= (i == int'(src));
                par_mem[src] <= src;
                que_mem[0] <= src;
                head_reg <= '0;
                tail_reg <= (IDX_W+1)'(1);
                neck_reg <= '1;
            end
            sv_reg <= 1'b0;
            if (cmd.bfs_pop) begin
                u_reg <= que_mem[head_reg[IDX_W-1:0]];
                head_reg <= head_reg + 1'b1;
                v_reg <= '0;
            end
            if (cmd.scan_step) begin
                v_reg <= v_reg + 1'b1;
                sv_reg <= 1'b1;
                w_reg <= v_reg;
            end
            if (sv_reg && !vis_reg[w_reg] && res_rd != '0) begin
                if (tail_reg < (IDX_W+1)'(MAX_NODES)) begin
                    que_mem[tail_reg[IDX_W-1:0]] <= w_reg;
                    tail_reg <= tail_reg + 1'b1;
                end
                vis_reg[w_reg] <= 1'b1;
                par_mem[w_reg] <= u_reg;
            end
            // Parent of the walk node, read one step ahead.
            if (cmd.walk_start) pw_reg <= par_mem[dst];
            else if (cmd.neck_step) pw_reg <= par_mem[pw_reg];
            else if (cmd.rev_step) pw_reg <= par_mem[wp_reg];
            if (cmd.walk_start) begin
                w_reg <= dst; steps_reg <= '0;
            end
            if (cmd.neck_step) begin
                w_reg <= pw_reg; steps_reg <= steps_reg + 1'b1;
            end
            nv_reg <= cmd.neck_step;
            if (nv_reg && res_rd < neck_reg) neck_reg <= res_rd;
            if (cmd.fwd_step) wp_reg <= pw_reg;
            rv_reg <= cmd.rev_step;
            if (cmd.rev_step) begin
                ra_reg <= {w_reg, wp_reg};
                w_reg <= wp_reg; steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.zero_flow) flow_reg <= '0;
            else if (cmd.add_flow) begin
                if ({6'd0, flow_reg} + 28'(neck_reg) > 28'(FLOW_LIMIT)) flow_reg <= FLOW_LIMIT;
                else flow_reg <= flow_reg + 22'(neck_reg);
            end
        end
    end

    logic [IDX_W:0] n_last;
    assign n_last = n_use - 1'b1;
    assign stat.clr_last   = clr_reg[AW];
    assign stat.copy_last  = cp_reg == {1'b0, {AW{1'b1}}};
    assign stat.queue_empty = head_reg >= tail_reg;
    assign stat.scan_last  = {1'b0, v_reg} == n_last;
    assign stat.scan_pend  = sv_reg;
    assign stat.sink_seen  = vis_reg[dst];
    assign stat.walk_last  = w_reg == src || steps_reg == (IDX_W+1)'(MAX_NODES);
    assign flow = flow_reg;
endmodule
`default_nettype wire

@@ sv/mfek_ctrl.sv @@
// Controller: state machine that sequences clear, copy, search and augment.
`default_nettype none
module mfek_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            run_take,
    input  wire logic            run_trivial,
    input  wire logic            out_free,
    input  wire mfek_pkg::stat_t stat,
    output mfek_pkg::cmd_t       cmd,
    output logic                 idle,
    output logic                 done
);
    import mfek_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        done = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = !stat.clr_last;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                idle = 1'b1;
                if (run_take) begin
                    cmd.zero_flow = 1'b1;
                    if (run_trivial) state_next = ST_DONE;
                    else begin
                        cmd.copy_start = 1'b1; state_next = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last) state_next = ST_BFS_INIT;
            end
            ST_BFS_INIT: begin
                cmd.bfs_init = 1'b1; state_next = ST_BFS_POP;
            end
            ST_BFS_POP: begin
                // Hold while the last scanned neighbour lands in the queue.
                if (!stat.scan_pend) begin
                    if (stat.queue_empty) begin
                        if (stat.sink_seen) begin
                            cmd.walk_start = 1'b1; state_next = ST_NECK;
                        end else state_next = ST_DONE;
                    end else begin
                        cmd.bfs_pop = 1'b1; state_next = ST_BFS_SCAN;
                    end
                end
            end
            ST_BFS_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) state_next = ST_BFS_POP;
            end
            ST_NECK: begin
                // One path edge per cycle; the last read is compared on the way out.
                if (stat.walk_last) begin
                    cmd.walk_start = 1'b1; state_next = ST_UPD_FWD;
                end else cmd.neck_step = 1'b1;
            end
            ST_UPD_FWD: begin
                if (stat.walk_last) begin
                    cmd.add_flow = 1'b1; state_next = ST_BFS_INIT;
                end else begin
                    cmd.fwd_step = 1'b1; state_next = ST_UPD_REV;
                end
            end
            ST_UPD_REV: begin
                cmd.rev_step = 1'b1; state_next = ST_UPD_FWD;
            end
            ST_DONE: begin
                done = 1'b1;
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/mfek_checker.sv @@
// Port-level checker for the max-flow engine, bound to the top level.
`default_nettype none
module mfek_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_command,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [21:0] m_total_flow
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_flow))
        else $error("result changed while stalled");
    a_no_take_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command |=> !s_ready)
        else $error("ready straight after run");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("active after reset");
endmodule
bind max_flow_edmonds_karp_top mfek_checker u_chk (.*);
`default_nettype wire

@@ tb/max_flow_edmonds_karp_top_test.sv @@
// Self-checking testbench for the max-flow engine: capacity writes, flow runs and checks.
module max_flow_edmonds_karp_top_test;
    import mfek_pkg::*;

    localparam int NODES = 64;

    typedef struct {
        logic        cmd;
        logic [5:0]  from_n;
        logic [5:0]  to_n;
        logic [15:0] cap;
    } graph_op_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_NODE_COUNT;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_WRITE;
    logic [5:0]  s_from_node = '0;
    logic [5:0]  s_to_node = '0;
    logic [15:0] s_capacity = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [21:0] m_total_flow;

    // Predictor state: our own copy of the capacities and the registers
    logic [15:0] cap_mat [NODES][NODES];
    int          node_cnt_cfg = 64;
    int          src_cfg = 0;
    int          snk_cfg = 1;

    graph_op_t   pending_ops[$];
    logic [21:0] flow_due[$];
    int          fail_count = 0;
    int          runs_checked = 0;
    int          writes_taken = 0;
    int          stalled_cycles = 0;
    bit          s_took = 1'b0;
    bit          calm = 1'b0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;

    max_flow_edmonds_karp_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_from_node (s_from_node),
        .s_to_node   (s_to_node),
        .s_capacity  (s_capacity),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_total_flow(m_total_flow)
    );

    always #2 aclk = ~aclk;

    // Edmonds-Karp over the predictor's capacity copy, residuals kept as ints
    function automatic logic [21:0] max_flow_of(int n_cfg, int src, int dst);
        int res [NODES][NODES];
        int par [NODES];
        bit seen [NODES];
        int fifo [NODES];
        int head, tail, u, v, n, neck, steps;
        int total;
        n = (n_cfg > NODES) ? NODES : n_cfg;
        total = 0;
        if (src >= n || dst >= n || src == dst)
            return '0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                res[i][j] = cap_mat[i][j];
        forever begin
            foreach (seen[i]) seen[i] = 1'b0;
            head = 0;
            tail = 0;
            fifo[tail++] = src;
            seen[src] = 1'b1;
            par[src] = src;
            while (head < tail) begin
                u = fifo[head++];
                for (v = 0; v < n; v++) begin
                    if (!seen[v] && res[u][v] > 0) begin
                        if (tail < NODES) fifo[tail++] = v;
                        seen[v] = 1'b1;
                        par[v] = u;
                    end
                end
            end
            if (!seen[dst]) break;
            neck = 32'h7FFFFFFF;
            v = dst;
            for (steps = 0; v != src && steps < NODES; steps++) begin
                if (res[par[v]][v] < neck) neck = res[par[v]][v];
                v = par[v];
            end
            v = dst;
            for (steps = 0; v != src && steps < NODES; steps++) begin
                res[par[v]][v] -= neck;
                res[v][par[v]] += neck;
                v = par[v];
            end
            total += neck;
            if (total > int'(FLOW_LIMIT)) total = FLOW_LIMIT;
        end
        return total[21:0];
    endfunction

    // Input side: predict on every transfer
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            s_took = 1'b1;
            if (s_command == CMD_WRITE) begin
                cap_mat[s_from_node][s_to_node] = s_capacity;
                writes_taken++;
            end else begin
                flow_due.push_back(max_flow_of(node_cnt_cfg, src_cfg, snk_cfg));
            end
        end
    end

    // Driver: advance to the next pending item once the current one has gone
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            s_took = 1'b0;
            if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                graph_op_t op;
                op = pending_ops.pop_front();
                s_valid     <= 1'b1;
                s_command   <= op.cmd;
                s_from_node <= op.from_n;
                s_to_node   <= op.to_n;
                s_capacity  <= op.cap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 9000;
        end
        if (hold_left > 0) begin
            hold_left--;
            stalled_cycles++;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // Monitor: compare each result transfer with the oldest expected flow
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (flow_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $realtime, m_total_flow);
                fail_count++;
            end else begin
                logic [21:0] want;
                want = flow_due.pop_front();
                runs_checked++;
                if (m_total_flow !== want) begin
                    $display("%0t: total_flow mismatch, expected %0d, actual %0d",
                             $realtime, want, m_total_flow);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[6:0];
        case (idx)
            REG_NODE_COUNT: node_cnt_cfg = value & 8'h7F;
            REG_SOURCE:     src_cfg = value & 8'h3F;
            REG_SINK:       snk_cfg = value & 8'h3F;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_graph(input int n, input int src, input int dst);
        write_reg(REG_NODE_COUNT, n);
        write_reg(REG_SOURCE, src);
        write_reg(REG_SINK, dst);
    endtask

    task automatic queue_op(input logic cmd, input int f, input int t, input int c);
        graph_op_t op;
        op.cmd    = cmd;
        op.from_n = f[5:0];
        op.to_n   = t[5:0];
        op.cap    = c[15:0];
        pending_ops.push_back(op);
    endtask

    // Hold until every item has gone and every flow has come back
    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_valid || flow_due.size() > 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(2, 10);
        if (r < 70) return 64;
        if (r < 80) return $urandom_range(65, 127);
        if (r < 88) return $urandom_range(0, 1);
        return $urandom_range(11, 63);
    endfunction

    initial begin
        int n, lim, k, f, t, c;
        foreach (cap_mat[i, j]) cap_mat[i][j] = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty graph, extreme capacities and indices, self edge
        queue_op(CMD_RUN, 0, 0, 0);
        queue_op(CMD_WRITE, 0, 1, 65535);
        queue_op(CMD_WRITE, 0, 63, 65535);
        queue_op(CMD_WRITE, 63, 1, 100);
        queue_op(CMD_WRITE, 63, 63, 7);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();
        // Too many nodes acts as the full size
        set_graph(127, 0, 1);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();
        // Node count below two: endpoints fall outside
        set_graph(1, 0, 1);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();
        // Endpoint outside the graph
        set_graph(3, 5, 1);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();
        // Source equals sink
        set_graph(64, 63, 63);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();
        // Sink at the top index
        set_graph(64, 0, 63);
        queue_op(CMD_RUN, 0, 0, 0);
        wait_drained();

        // Random phases: a graph of edges among the nodes in use, then a run
        for (int ph = 0; ph < 69; ph++) begin
            calm = (ph >= 12 && ph < 20);
            n = (ph == 5) ? 2 : pick_count();
            lim = (n > 12) ? 12 : ((n < 2) ? 2 : n);
            if ($urandom_range(9) == 0)
                set_graph(n, $urandom_range(63), $urandom_range(63));
            else
                set_graph(n, $urandom_range(lim - 1), $urandom_range(lim - 1));
            if (ph == 30) hold_req = 1'b1;
            k = $urandom_range(5, 30);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(9) == 0) begin
                    f = $urandom_range(63);
                    t = $urandom_range(63);
                end else begin
                    f = $urandom_range(lim - 1);
                    t = $urandom_range(lim - 1);
                end
                case ($urandom_range(3))
                    0: c = 0;
                    1: c = $urandom_range(65535);
                    default: c = $urandom_range(1, 1000);
                endcase
                queue_op(CMD_WRITE, f, t, c);
                // a run mid-stream holds the writes behind it back until its result has gone
                if (i == 2 && (ph == 30 || $urandom_range(4) == 0))
                    queue_op(CMD_RUN, 0, 0, 0);
            end
            queue_op(CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom);
            wait_drained();
        end
        calm = 1'b0;

        repeat (200) @(negedge aclk);
        $display("Covered %0d capacity writes and %0d flow runs, %0d cycles of held-off results.",
                 writes_taken, runs_checked, stalled_cycles);
        if (fail_count == 0 && flow_due.size() == 0)
            $display("max_flow_edmonds_karp_top_test: PASS");
        else
            $display("max_flow_edmonds_karp_top_test: FAIL");
        $finish;
    end

    initial begin
        #40000000;
        $display("Timed out with %0d flows outstanding.", flow_due.size());
        $display("max_flow_edmonds_karp_top_test: FAIL");
        $finish;
    end
endmodule
